FILE: design/stc_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the scaled tile margin calculator
// no dependencies

package stc_pkg;

    // width of the scaled size and offset fields
    localparam int SCALED_BITS = 24;

    // configuration register index width
    localparam int CFG_ADDR_W = 2;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_SCENE_W = 2'd0,
        CFG_SCENE_H = 2'd1,
        CFG_MARGIN  = 2'd2
    } t_cfg_reg;

endpackage

FILE: design/stc_div_pipe.sv
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, with sideband
// standalone, used by scaled_tile_margin_calc

module stc_div_pipe #(
    parameter int NUM_W  = 38,
    parameter int DEN_W  = 17,
    parameter int SIDE_W = 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  logic [NUM_W-1:0]  i_num,
    input  logic [DEN_W-1:0]  i_den,
    input  logic [SIDE_W-1:0] i_side,
    output logic              o_valid,
    output logic [NUM_W-1:0]  o_quot,
    output logic [SIDE_W-1:0] o_side
);

    logic [NUM_W-1:0]  r_num  [NUM_W];
    logic [NUM_W-1:0]  r_quo  [NUM_W];
    logic [DEN_W-1:0]  r_rem  [NUM_W];
    logic [DEN_W-1:0]  r_den  [NUM_W];
    logic [SIDE_W-1:0] r_side [NUM_W];
    logic [NUM_W-1:0]  r_vld;

    for (genvar g = 0; g < NUM_W; g++) begin : g_stage
        logic [NUM_W-1:0]  w_num;
        logic [NUM_W-1:0]  w_quo;
        logic [DEN_W-1:0]  w_rem;
        logic [DEN_W-1:0]  w_den;
        logic [SIDE_W-1:0] w_side;
        logic              w_vld;
        logic [DEN_W:0]    w_trial;
        logic [DEN_W:0]    w_diff;
        logic              w_ge;

        if (g == 0) begin : g_first
            assign w_num  = i_num;
            assign w_quo  = '0;
            assign w_rem  = '0;
            assign w_den  = i_den;
            assign w_side = i_side;
            assign w_vld  = i_valid;
        end else begin : g_next
            assign w_num  = r_num[g-1];
            assign w_quo  = r_quo[g-1];
            assign w_rem  = r_rem[g-1];
            assign w_den  = r_den[g-1];
            assign w_side = r_side[g-1];
            assign w_vld  = r_vld[g-1];
        end

        // shift in next numerator bit, subtract when it fits
        assign w_trial = {w_rem, w_num[NUM_W-1]};
        assign w_diff  = w_trial - {1'b0, w_den};
        assign w_ge    = (w_trial >= {1'b0, w_den});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[g]  <= {w_num[NUM_W-2:0], 1'b0};
                r_quo[g]  <= {w_quo[NUM_W-2:0], w_ge};
                r_rem[g]  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_den[g]  <= w_den;
                r_side[g] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[NUM_W-1];
    assign o_quot  = r_quo[NUM_W-1];
    assign o_side  = r_side[NUM_W-1];

endmodule

FILE: design/scaled_tile_margin_calc.sv
`timescale 1ns / 1ps
// top level of the scaled tile margin calculator
// depends on stc_pkg and stc_div_pipe

// Takes one tile word per cycle while o_ready is high and returns one
// result word per input word, in order. Two banks of pipelined
// dividers do the division: one finds the margin in source pixels per
// axis, the other scales the grown size and the tile offset back to output
// pixels. Every stage is registered and the whole pipeline moves together;
// o_ready is high whenever the output register is empty or being taken, so
// the sustained rate is one word per cycle while the consumer keeps up.
// Rounding is half up on exact rational values; scaled fields saturate at
// all ones. Configuration is written through i_cfg_we / i_cfg_addr /
// i_cfg_wdata and should only change while the pipeline is empty.

module scaled_tile_margin_calc
    import stc_pkg::*;
#(
    parameter int COORD_BITS = 20,
    parameter int SIZE_BITS  = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // configuration write port
    input  logic                       i_cfg_we,
    input  logic [CFG_ADDR_W-1:0]      i_cfg_addr,
    input  logic [((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS)-1:0] i_cfg_wdata,
    // input word
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [COORD_BITS-1:0]      i_tile_x,
    input  logic [COORD_BITS-1:0]      i_tile_y,
    input  logic [COORD_BITS-1:0]      i_tile_w,
    input  logic [COORD_BITS-1:0]      i_tile_h,
    input  logic [SIZE_BITS-1:0]       i_out_w,
    input  logic [SIZE_BITS-1:0]       i_out_h,
    // result word
    output logic                       o_valid,
    input  logic                       i_ready,
    output logic [COORD_BITS-1:0]      o_grown_x,
    output logic [COORD_BITS-1:0]      o_grown_y,
    output logic [COORD_BITS-1:0]      o_grown_w,
    output logic [COORD_BITS-1:0]      o_grown_h,
    output logic [SCALED_BITS-1:0]     o_scaled_w,
    output logic [SCALED_BITS-1:0]     o_scaled_h,
    output logic [SCALED_BITS-1:0]     o_offset_x,
    output logic [SCALED_BITS-1:0]     o_offset_y
);

    localparam int CW     = COORD_BITS;
    localparam int SW     = SIZE_BITS;
    localparam int PROD_W = CW + SW;
    localparam int DNUM_W = CW + SW + 2;   // doubled product plus rounding term
    localparam int GW     = CW + 4;        // signed edge arithmetic
    localparam int MG_W   = CW + 3;        // capped margin
    localparam int MSIDE_W = 2 * CW + SW;
    localparam int SSIDE_W = 2 * CW + 1;

    localparam logic [DNUM_W-1:0] MCAP = DNUM_W'(1) << (CW + 2);
    localparam logic [DNUM_W-1:0] SMAX = DNUM_W'({SCALED_BITS{1'b1}});

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [CW-1:0] r_scene_w;
    logic [CW-1:0] r_scene_h;
    logic [SW-1:0] r_margin;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scene_w <= '0;
            r_scene_h <= '0;
            r_margin  <= '0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_reg'(i_cfg_addr))
                CFG_SCENE_W: r_scene_w <= i_cfg_wdata[CW-1:0];
                CFG_SCENE_H: r_scene_h <= i_cfg_wdata[CW-1:0];
                CFG_MARGIN:  r_margin  <= i_cfg_wdata[SW-1:0];
                default: ;  // writes beyond the list are dropped
            endcase
        end
    end

    // global advance: the output register is free or being taken
    logic w_en;
    logic r_out_vld;

    assign w_en    = !r_out_vld || i_ready;
    assign o_ready = w_en;

    // ------------------------------------------------------------------
    // stage 1: capture word, margin times tile size
    // ------------------------------------------------------------------
    logic              r1_vld;
    logic [CW-1:0]     r1_tx, r1_ty, r1_tw, r1_th;
    logic [SW-1:0]     r1_ow, r1_oh;
    logic [PROD_W-1:0] r1_pmx, r1_pmy;
    logic [PROD_W-1:0] n1_pmx, n1_pmy;

    assign n1_pmx = PROD_W'(r_margin) * PROD_W'(i_tile_w);
    assign n1_pmy = PROD_W'(r_margin) * PROD_W'(i_tile_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_tx  <= i_tile_x;
            r1_ty  <= i_tile_y;
            r1_tw  <= i_tile_w;
            r1_th  <= i_tile_h;
            r1_ow  <= i_out_w;
            r1_oh  <= i_out_h;
            r1_pmx <= n1_pmx;
            r1_pmy <= n1_pmy;
        end
    end

    // ------------------------------------------------------------------
    // margin dividers: (2*m*t + o) / (2*o)
    // a zero output size divides by zero and yields all ones, which the
    // cap below turns into the unbounded margin
    // ------------------------------------------------------------------
    logic [DNUM_W-1:0]  w_mnum_x, w_mnum_y;
    logic [DNUM_W-1:0]  w_mq_x, w_mq_y;
    logic [MSIDE_W-1:0] w_mside_x, w_mside_y;
    logic               w_mvld_x, w_mvld_y;

    assign w_mnum_x = {1'b0, r1_pmx, 1'b0} + DNUM_W'(r1_ow);
    assign w_mnum_y = {1'b0, r1_pmy, 1'b0} + DNUM_W'(r1_oh);

    stc_div_pipe #(
        .NUM_W  (DNUM_W),
        .DEN_W  (SW + 1),
        .SIDE_W (MSIDE_W)
    ) u_mdiv_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   (w_mnum_x),
        .i_den   ({r1_ow, 1'b0}),
        .i_side  ({r1_tx, r1_tw, r1_ow}),
        .o_valid (w_mvld_x),
        .o_quot  (w_mq_x),
        .o_side  (w_mside_x)
    );

    stc_div_pipe #(
        .NUM_W  (DNUM_W),
        .DEN_W  (SW + 1),
        .SIDE_W (MSIDE_W)
    ) u_mdiv_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r1_vld),
        .i_num   (w_mnum_y),
        .i_den   ({r1_oh, 1'b0}),
        .i_side  ({r1_ty, r1_th, r1_oh}),
        .o_valid (w_mvld_y),
        .o_quot  (w_mq_y),
        .o_side  (w_mside_y)
    );

    // ------------------------------------------------------------------
    // stage 2: grow by the margin and clip each edge to the scene
    // ------------------------------------------------------------------
    logic [CW-1:0]   w2_tx, w2_tw, w2_ty, w2_th;
    logic [SW-1:0]   w2_ow, w2_oh;
    logic [MG_W-1:0] w2_mx, w2_my;
    logic signed [GW-1:0] w2_lo_x, w2_hi_x, w2_lo_y, w2_hi_y;
    logic signed [GW-1:0] w2_lim_x, w2_lim_y;

    assign {w2_tx, w2_tw, w2_ow} = w_mside_x;
    assign {w2_ty, w2_th, w2_oh} = w_mside_y;

    assign w2_mx = (w_mq_x > MCAP) ? MG_W'(MCAP) : w_mq_x[MG_W-1:0];
    assign w2_my = (w_mq_y > MCAP) ? MG_W'(MCAP) : w_mq_y[MG_W-1:0];

    assign w2_lo_x  = $signed(GW'(w2_tx)) - $signed(GW'(w2_mx));
    assign w2_hi_x  = $signed(GW'(w2_tx)) + $signed(GW'(w2_tw)) + $signed(GW'(w2_mx));
    assign w2_lo_y  = $signed(GW'(w2_ty)) - $signed(GW'(w2_my));
    assign w2_hi_y  = $signed(GW'(w2_ty)) + $signed(GW'(w2_th)) + $signed(GW'(w2_my));
    assign w2_lim_x = $signed(GW'(r_scene_w));
    assign w2_lim_y = $signed(GW'(r_scene_h));

    logic                 r2_vld;
    logic signed [GW-1:0] r2_lo_x, r2_hi_x, r2_lo_y, r2_hi_y;
    logic [CW-1:0]        r2_tx, r2_ty, r2_tw, r2_th;
    logic [SW-1:0]        r2_ow, r2_oh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_vld <= 1'b0;
        end else if (w_en) begin
            r2_vld <= w_mvld_x && w_mvld_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_lo_x <= (w2_lo_x < 0) ? '0 : w2_lo_x;
            r2_hi_x <= (w2_hi_x > w2_lim_x) ? w2_lim_x : w2_hi_x;
            r2_lo_y <= (w2_lo_y < 0) ? '0 : w2_lo_y;
            r2_hi_y <= (w2_hi_y > w2_lim_y) ? w2_lim_y : w2_hi_y;
            r2_tx   <= w2_tx;
            r2_ty   <= w2_ty;
            r2_tw   <= w2_tw;
            r2_th   <= w2_th;
            r2_ow   <= w2_ow;
            r2_oh   <= w2_oh;
        end
    end

    // ------------------------------------------------------------------
    // stage 3: empty check, grown size and tile offset
    // ------------------------------------------------------------------
    logic                 w3_empty;
    logic signed [GW-1:0] w3_dw, w3_dh;
    logic [CW-1:0]        w3_gx, w3_gy, w3_gw, w3_gh;

    // empty on either axis zeroes the whole rectangle
    assign w3_empty = !((r2_hi_x > r2_lo_x) && (r2_hi_y > r2_lo_y));
    assign w3_dw    = r2_hi_x - r2_lo_x;
    assign w3_dh    = r2_hi_y - r2_lo_y;
    assign w3_gx    = w3_empty ? '0 : r2_lo_x[CW-1:0];
    assign w3_gy    = w3_empty ? '0 : r2_lo_y[CW-1:0];
    assign w3_gw    = w3_empty ? '0 : w3_dw[CW-1:0];
    assign w3_gh    = w3_empty ? '0 : w3_dh[CW-1:0];

    logic          r3_vld;
    logic [CW-1:0] r3_gx, r3_gy, r3_gw, r3_gh, r3_ox, r3_oy, r3_tw, r3_th;
    logic [SW-1:0] r3_ow, r3_oh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else if (w_en) begin
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_gx <= w3_gx;
            r3_gy <= w3_gy;
            r3_gw <= w3_gw;
            r3_gh <= w3_gh;
            r3_ox <= r2_tx - w3_gx;  // grown edge never passes the tile edge
            r3_oy <= r2_ty - w3_gy;
            r3_tw <= r2_tw;
            r3_th <= r2_th;
            r3_ow <= r2_ow;
            r3_oh <= r2_oh;
        end
    end

    // ------------------------------------------------------------------
    // stage 4: numerators times output size, zero flags
    // ------------------------------------------------------------------
    logic              r4_vld;
    logic [PROD_W-1:0] r4_pw, r4_ph, r4_px, r4_py;
    logic              r4_zw, r4_zh, r4_zx, r4_zy;
    logic [CW-1:0]     r4_gx, r4_gy, r4_gw, r4_gh, r4_tw, r4_th;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_vld <= 1'b0;
        end else if (w_en) begin
            r4_vld <= r3_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_pw <= PROD_W'(r3_gw) * PROD_W'(r3_ow);
            r4_ph <= PROD_W'(r3_gh) * PROD_W'(r3_oh);
            r4_px <= PROD_W'(r3_ox) * PROD_W'(r3_ow);
            r4_py <= PROD_W'(r3_oy) * PROD_W'(r3_oh);
            r4_zw <= (r3_gw == '0) || (r3_ow == '0);
            r4_zh <= (r3_gh == '0) || (r3_oh == '0);
            r4_zx <= (r3_ox == '0) || (r3_ow == '0);
            r4_zy <= (r3_oy == '0) || (r3_oh == '0);
            r4_gx <= r3_gx;
            r4_gy <= r3_gy;
            r4_gw <= r3_gw;
            r4_gh <= r3_gh;
            r4_tw <= r3_tw;
            r4_th <= r3_th;
        end
    end

    // ------------------------------------------------------------------
    // scale dividers: (2*n*o + t) / (2*t)
    // zero tile size gives all ones, which saturates
    // ------------------------------------------------------------------
    logic [DNUM_W-1:0]  w_sq_w, w_sq_h, w_sq_x, w_sq_y;
    logic [SSIDE_W-1:0] w_sside_w, w_sside_h;
    logic               w_sz_x, w_sz_y;
    logic               w_svld_w, w_svld_h, w_svld_x, w_svld_y;

    stc_div_pipe #(
        .NUM_W  (DNUM_W),
        .DEN_W  (CW + 1),
        .SIDE_W (SSIDE_W)
    ) u_sdiv_w (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_num   ({1'b0, r4_pw, 1'b0} + DNUM_W'(r4_tw)),
        .i_den   ({r4_tw, 1'b0}),
        .i_side  ({r4_zw, r4_gx, r4_gw}),
        .o_valid (w_svld_w),
        .o_quot  (w_sq_w),
        .o_side  (w_sside_w)
    );

    stc_div_pipe #(
        .NUM_W  (DNUM_W),
        .DEN_W  (CW + 1),
        .SIDE_W (SSIDE_W)
    ) u_sdiv_h (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_num   ({1'b0, r4_ph, 1'b0} + DNUM_W'(r4_th)),
        .i_den   ({r4_th, 1'b0}),
        .i_side  ({r4_zh, r4_gy, r4_gh}),
        .o_valid (w_svld_h),
        .o_quot  (w_sq_h),
        .o_side  (w_sside_h)
    );

    stc_div_pipe #(
        .NUM_W  (DNUM_W),
        .DEN_W  (CW + 1),
        .SIDE_W (1)
    ) u_sdiv_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_num   ({1'b0, r4_px, 1'b0} + DNUM_W'(r4_tw)),
        .i_den   ({r4_tw, 1'b0}),
        .i_side  (r4_zx),
        .o_valid (w_svld_x),
        .o_quot  (w_sq_x),
        .o_side  (w_sz_x)
    );

    stc_div_pipe #(
        .NUM_W  (DNUM_W),
        .DEN_W  (CW + 1),
        .SIDE_W (1)
    ) u_sdiv_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r4_vld),
        .i_num   ({1'b0, r4_py, 1'b0} + DNUM_W'(r4_th)),
        .i_den   ({r4_th, 1'b0}),
        .i_side  (r4_zy),
        .o_valid (w_svld_y),
        .o_quot  (w_sq_y),
        .o_side  (w_sz_y)
    );

    // ------------------------------------------------------------------
    // output register: zero flags, saturation
    // ------------------------------------------------------------------
    logic          w5_zw, w5_zh;
    logic [CW-1:0] w5_gx, w5_gy, w5_gw, w5_gh;

    assign {w5_zw, w5_gx, w5_gw} = w_sside_w;
    assign {w5_zh, w5_gy, w5_gh} = w_sside_h;

    logic [CW-1:0]          r_gx, r_gy, r_gw, r_gh;
    logic [SCALED_BITS-1:0] r_sw, r_sh, r_ox, r_oy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= w_svld_w && w_svld_h && w_svld_x && w_svld_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_gx <= w5_gx;
            r_gy <= w5_gy;
            r_gw <= w5_gw;
            r_gh <= w5_gh;
            r_sw <= w5_zw ? '0 : ((w_sq_w > SMAX) ? '1 : w_sq_w[SCALED_BITS-1:0]);
            r_sh <= w5_zh ? '0 : ((w_sq_h > SMAX) ? '1 : w_sq_h[SCALED_BITS-1:0]);
            r_ox <= w_sz_x ? '0 : ((w_sq_x > SMAX) ? '1 : w_sq_x[SCALED_BITS-1:0]);
            r_oy <= w_sz_y ? '0 : ((w_sq_y > SMAX) ? '1 : w_sq_y[SCALED_BITS-1:0]);
        end
    end

    assign o_valid    = r_out_vld;
    assign o_grown_x  = r_gx;
    assign o_grown_y  = r_gy;
    assign o_grown_w  = r_gw;
    assign o_grown_h  = r_gh;
    assign o_scaled_w = r_sw;
    assign o_scaled_h = r_sh;
    assign o_offset_x = r_ox;
    assign o_offset_y = r_oy;

endmodule
